FILE: rtl/core/wfc_pkg.sv
// shared constants, codes and types of the word frequency counter
package wfc_pkg;

  localparam int TABLE_ENTRIES  = 1024;
  localparam int MAX_WORD_CHARS = 16;
  localparam int COUNT_BITS     = 32;
  localparam int QUEUE_DEPTH    = 2;

  localparam int IDX_W      = $clog2(TABLE_ENTRIES);
  localparam int USED_W     = $clog2(TABLE_ENTRIES + 1);
  localparam int LEN_W      = $clog2(MAX_WORD_CHARS + 1);
  localparam int CHAR_IDX_W = $clog2(MAX_WORD_CHARS);
  localparam int HALF_BITS  = 64;

  localparam logic [1:0] KIND_TEXT  = 2'd0;
  localparam logic [1:0] KIND_FLUSH = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  typedef enum logic [2:0] {
    ST_MATCHED = 3'd0,
    ST_ADDED   = 3'd1,
    ST_DROPPED = 3'd2,
    ST_READ    = 3'd3,
    ST_RANGE   = 3'd4
  } status_t;

  typedef enum logic {
    CMD_WORD = 1'b0,
    CMD_READ = 1'b1
  } cmd_op_t;

  typedef logic [MAX_WORD_CHARS-1:0][7:0] word_t;

  typedef struct packed {
    cmd_op_t          op;
    word_t            word;
    logic [LEN_W-1:0] len;
    logic             trunc;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    word_t                 word;
    logic [LEN_W-1:0]      len;
    logic [COUNT_BITS-1:0] count;
  } entry_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_READ_WAIT,
    BK_EMIT
  } back_state_t;

endpackage

FILE: rtl/core/wfc_ram.sv
// generic single write port ram with registered read
module wfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/wfc_front.sv
// front end: takes input transactions, builds the pending word, issues commands
module wfc_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  logic [1:0]                 kind,
  input  logic [7:0]                 text_byte,
  input  logic [wfc_pkg::IDX_W-1:0]  entry_index,
  output logic                       q_push,
  output wfc_pkg::cmd_t              q_cmd,
  input  logic                       q_ready
);
  import wfc_pkg::*;

  word_t            pend_word;
  logic [LEN_W-1:0] pend_len;
  logic             pend_ovf;
  logic             is_letter;
  logic             has_word;
  logic             push_req;
  logic             accept;

  always_comb begin
    is_letter = text_byte inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    has_word  = pend_len != '0;
    case (kind)
      KIND_TEXT:  push_req = !is_letter && has_word;
      KIND_FLUSH: push_req = has_word;
      KIND_READ:  push_req = 1'b1;
      default:    push_req = 1'b0;
    endcase
    item_ready = !push_req || q_ready;
    accept     = item_valid && item_ready;
    q_push     = accept && push_req;
    q_cmd.op    = (kind == KIND_READ) ? CMD_READ : CMD_WORD;
    q_cmd.word  = pend_word;
    q_cmd.len   = pend_len;
    q_cmd.trunc = pend_ovf;
    q_cmd.idx   = entry_index;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_word <= '0;
      pend_len  <= '0;
      pend_ovf  <= 1'b0;
    end else if (accept) begin
      if (kind == KIND_TEXT && is_letter) begin
        if (pend_len < LEN_W'(MAX_WORD_CHARS)) begin
          pend_word[pend_len[CHAR_IDX_W-1:0]] <= text_byte;
          pend_len <= pend_len + LEN_W'(1);
        end else begin
          pend_ovf <= 1'b1;
        end
      end else if (q_push && kind != KIND_READ) begin
        pend_word <= '0;
        pend_len  <= '0;
        pend_ovf  <= 1'b0;
      end
    end
  end
endmodule

FILE: rtl/core/wfc_queue.sv
// short command queue between front and back
module wfc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  wfc_pkg::cmd_t push_cmd,
  output logic          push_ready,
  input  logic          pop,
  output wfc_pkg::cmd_t pop_cmd,
  output logic          pop_valid
);
  import wfc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end
endmodule

FILE: rtl/core/wfc_back.sv
// back end: table search, update, read out and result register
module wfc_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  wfc_pkg::cmd_t                  q_cmd,
  output logic                           q_pop,
  output logic                           result_valid,
  input  logic                           result_ready,
  output logic [2:0]                     status,
  output logic [wfc_pkg::IDX_W-1:0]      entry_position,
  output logic [63:0]                    word_low,
  output logic [63:0]                    word_high,
  output logic [wfc_pkg::LEN_W-1:0]      word_length,
  output logic [wfc_pkg::COUNT_BITS-1:0] occurrences,
  output logic [wfc_pkg::USED_W-1:0]     entries_used,
  output logic                           truncated
);
  import wfc_pkg::*;

  back_state_t           state;
  back_state_t           state_next;
  cmd_t                  cur;
  logic [USED_W-1:0]     used;
  logic [USED_W-1:0]     used_next;
  logic [USED_W-1:0]     scan_addr;
  logic [USED_W-1:0]     scan_addr_next;
  logic                  cmp_valid;
  logic                  cmp_valid_next;
  logic [IDX_W-1:0]      cmp_addr;
  logic [IDX_W-1:0]      cmp_addr_next;

  status_t               res_status;
  status_t               res_status_next;
  logic [IDX_W-1:0]      res_pos;
  logic [IDX_W-1:0]      res_pos_next;
  word_t                 res_word;
  word_t                 res_word_next;
  logic [LEN_W-1:0]      res_len;
  logic [LEN_W-1:0]      res_len_next;
  logic [COUNT_BITS-1:0] res_occ;
  logic [COUNT_BITS-1:0] res_occ_next;
  logic                  res_trunc;
  logic                  res_trunc_next;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  entry_t                ram_wdata;
  logic [IDX_W-1:0]      ram_raddr;
  entry_t                ram_rdata;
  logic                  load_out;
  logic                  hit;
  logic [COUNT_BITS-1:0] count_inc;

  wfc_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_next      = state;
    used_next       = used;
    scan_addr_next  = scan_addr;
    cmp_valid_next  = 1'b0;
    cmp_addr_next   = cmp_addr;
    res_status_next = res_status;
    res_pos_next    = res_pos;
    res_word_next   = res_word;
    res_len_next    = res_len;
    res_occ_next    = res_occ;
    res_trunc_next  = res_trunc;
    ram_we          = 1'b0;
    ram_waddr       = cmp_addr;
    ram_wdata       = ram_rdata;
    ram_raddr       = scan_addr[IDX_W-1:0];
    q_pop           = 1'b0;
    load_out        = 1'b0;
    hit             = ram_rdata.len == cur.len && ram_rdata.word == cur.word;
    count_inc       = (ram_rdata.count == '1) ? ram_rdata.count
                                              : ram_rdata.count + COUNT_BITS'(1);
    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          ram_raddr = q_cmd.idx;
          if (q_cmd.op == CMD_READ) begin
            if ({1'b0, q_cmd.idx} < used) begin
              state_next = BK_READ_WAIT;
            end else begin
              res_status_next = ST_RANGE;
              res_pos_next    = '0;
              res_word_next   = '0;
              res_len_next    = '0;
              res_occ_next    = '0;
              res_trunc_next  = 1'b0;
              state_next      = BK_EMIT;
            end
          end else begin
            scan_addr_next = '0;
            state_next     = BK_SCAN;
          end
        end
      end
      BK_SCAN: begin
        res_word_next  = cur.word;
        res_len_next   = cur.len;
        res_trunc_next = cur.trunc;
        if (scan_addr < used) begin
          cmp_valid_next = 1'b1;
          cmp_addr_next  = scan_addr[IDX_W-1:0];
          scan_addr_next = scan_addr + USED_W'(1);
        end
        if (cmp_valid && hit) begin
          ram_we          = 1'b1;
          ram_waddr       = cmp_addr;
          ram_wdata.word  = cur.word;
          ram_wdata.len   = cur.len;
          ram_wdata.count = count_inc;
          res_status_next = ST_MATCHED;
          res_pos_next    = cmp_addr;
          res_occ_next    = count_inc;
          cmp_valid_next  = 1'b0;
          state_next      = BK_EMIT;
        end else if (!cmp_valid && scan_addr >= used) begin
          cmp_valid_next = 1'b0;
          if (used >= USED_W'(TABLE_ENTRIES)) begin
            res_status_next = ST_DROPPED;
            res_pos_next    = '0;
            res_occ_next    = '0;
          end else begin
            ram_we          = 1'b1;
            ram_waddr       = used[IDX_W-1:0];
            ram_wdata.word  = cur.word;
            ram_wdata.len   = cur.len;
            ram_wdata.count = COUNT_BITS'(1);
            res_status_next = ST_ADDED;
            res_pos_next    = used[IDX_W-1:0];
            res_occ_next    = COUNT_BITS'(1);
            used_next       = used + USED_W'(1);
          end
          state_next = BK_EMIT;
        end
      end
      BK_READ_WAIT: begin
        res_status_next = ST_READ;
        res_pos_next    = cur.idx;
        res_word_next   = ram_rdata.word;
        res_len_next    = ram_rdata.len;
        res_occ_next    = ram_rdata.count;
        res_trunc_next  = 1'b0;
        state_next      = BK_EMIT;
      end
      BK_EMIT: begin
        if (!result_valid || result_ready) begin
          load_out   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_IDLE;
      used         <= '0;
      cmp_valid    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state     <= state_next;
      used      <= used_next;
      cmp_valid <= cmp_valid_next;
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_cmd;
    end
    scan_addr  <= scan_addr_next;
    cmp_addr   <= cmp_addr_next;
    res_status <= res_status_next;
    res_pos    <= res_pos_next;
    res_word   <= res_word_next;
    res_len    <= res_len_next;
    res_occ    <= res_occ_next;
    res_trunc  <= res_trunc_next;
    if (load_out) begin
      status         <= res_status;
      entry_position <= res_pos;
      word_low       <= res_word[HALF_BITS/8-1:0];
      word_high      <= res_word[MAX_WORD_CHARS-1:HALF_BITS/8];
      word_length    <= res_len;
      occurrences    <= res_occ;
      entries_used   <= used;
      truncated      <= res_trunc;
    end
  end

`ifndef ASSERT_OFF
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= USED_W'(TABLE_ENTRIES))
    else $error("entry count beyond table depth");

  a_used_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (used == $past(used) || used == $past(used) + USED_W'(1)))
    else $error("entry count moved by more than one");

  a_write_scan: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == BK_SCAN)
    else $error("table write outside a search");

  a_match_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == ST_MATCHED |-> occurrences != '0)
    else $error("matched word reported with zero count");
`endif
endmodule

FILE: rtl/core/word_frequency_counter.sv
// top level of the word frequency counter
//
//   channel  handshake                   payload
//   item     item_valid / item_ready     kind, text_byte, entry_index
//   result   result_valid / result_ready status, entry_position, word_low, word_high,
//                                        word_length, occurrences, entries_used, truncated
//
// letters are taken one per cycle by the front end; a finished word or a read
// goes through a two-entry command queue to the back end
// in the back end the search for a finished word reads one table entry per cycle
// through the single ram read port; a table read goes through BK_READ_WAIT to BK_EMIT,
// one out of range straight to BK_EMIT; reset clears control state only, and table
// entries at or beyond entries_used are never used, so the table needs no clearing pass
// a full queue stalls only items that finish a word or read; a held result
// stalls the back end
module word_frequency_counter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  logic [1:0]                     kind,
  input  logic [7:0]                     text_byte,
  input  logic [wfc_pkg::IDX_W-1:0]      entry_index,
  output logic                           result_valid,
  input  logic                           result_ready,
  output logic [2:0]                     status,
  output logic [wfc_pkg::IDX_W-1:0]      entry_position,
  output logic [63:0]                    word_low,
  output logic [63:0]                    word_high,
  output logic [wfc_pkg::LEN_W-1:0]      word_length,
  output logic [wfc_pkg::COUNT_BITS-1:0] occurrences,
  output logic [wfc_pkg::USED_W-1:0]     entries_used,
  output logic                           truncated
);
  import wfc_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic push_ready;
  logic pop;
  cmd_t pop_cmd;
  logic pop_valid;

  wfc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .kind       (kind),
    .text_byte  (text_byte),
    .entry_index(entry_index),
    .q_push     (push),
    .q_cmd      (push_cmd),
    .q_ready    (push_ready)
  );

  wfc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .push_ready(push_ready),
    .pop       (pop),
    .pop_cmd   (pop_cmd),
    .pop_valid (pop_valid)
  );

  wfc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (pop_valid),
    .q_cmd         (pop_cmd),
    .q_pop         (pop),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .status        (status),
    .entry_position(entry_position),
    .word_low      (word_low),
    .word_high     (word_high),
    .word_length   (word_length),
    .occurrences   (occurrences),
    .entries_used  (entries_used),
    .truncated     (truncated)
  );
endmodule

FILE: sim/wfc_checker.sv
// checker for the word frequency counter: tracks the word table and compares every result
module wfc_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  input  logic                           item_ready,
  input  logic [1:0]                     kind,
  input  logic [7:0]                     text_byte,
  input  logic [wfc_pkg::IDX_W-1:0]      entry_index,
  input  logic                           result_valid,
  input  logic                           result_ready,
  input  logic [2:0]                     status,
  input  logic [wfc_pkg::IDX_W-1:0]      entry_position,
  input  logic [63:0]                    word_low,
  input  logic [63:0]                    word_high,
  input  logic [wfc_pkg::LEN_W-1:0]      word_length,
  input  logic [wfc_pkg::COUNT_BITS-1:0] occurrences,
  input  logic [wfc_pkg::USED_W-1:0]     entries_used,
  input  logic                           truncated,
  output int                             mismatches,
  output int                             results_owed,
  output int                             words_stored
);
  import wfc_pkg::*;

  typedef struct packed {
    status_t               status;
    logic [IDX_W-1:0]      pos;
    logic [63:0]           lo;
    logic [63:0]           hi;
    logic [LEN_W-1:0]      len;
    logic [COUNT_BITS-1:0] occ;
    logic [USED_W-1:0]     used;
    logic                  trunc;
  } tally_t;

  tally_t                tally_q[$];
  logic [127:0]          tbl_word  [TABLE_ENTRIES];
  logic [LEN_W-1:0]      tbl_len   [TABLE_ENTRIES];
  logic [COUNT_BITS-1:0] tbl_count [TABLE_ENTRIES];
  int                    n_used = 0;
  logic [127:0]          cur_word = '0;
  int                    cur_len = 0;
  logic                  cur_over = 1'b0;
  int                    miss_count = 0;
  int                    owed_n = 0;

  assign mismatches   = miss_count;
  assign results_owed = owed_n;
  assign words_stored = n_used;

  function automatic bit is_letter(logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic tally_t close_word();
    tally_t t;
    int     hit;
    hit = -1;
    for (int i = 0; i < n_used; i++) begin
      if (hit < 0 && tbl_len[i] == LEN_W'(cur_len) && tbl_word[i] == cur_word) hit = i;
    end
    t.lo    = cur_word[63:0];
    t.hi    = cur_word[127:64];
    t.len   = LEN_W'(cur_len);
    t.trunc = cur_over;
    if (hit >= 0) begin
      if (tbl_count[hit] != '1) tbl_count[hit] = tbl_count[hit] + 1'b1;
      t.status = ST_MATCHED;
      t.pos    = IDX_W'(hit);
      t.occ    = tbl_count[hit];
    end else if (n_used >= TABLE_ENTRIES) begin
      t.status = ST_DROPPED;
      t.pos    = '0;
      t.occ    = '0;
    end else begin
      tbl_word[n_used]  = cur_word;
      tbl_len[n_used]   = LEN_W'(cur_len);
      tbl_count[n_used] = 1;
      t.status = ST_ADDED;
      t.pos    = IDX_W'(n_used);
      t.occ    = 1;
      n_used++;
    end
    t.used   = USED_W'(n_used);
    cur_word = '0;
    cur_len  = 0;
    cur_over = 1'b0;
    return t;
  endfunction

  function automatic tally_t read_entry(logic [IDX_W-1:0] idx);
    tally_t t;
    t = '0;
    if (idx < n_used) begin
      t.status = ST_READ;
      t.pos    = idx;
      t.lo     = tbl_word[idx][63:0];
      t.hi     = tbl_word[idx][127:64];
      t.len    = tbl_len[idx];
      t.occ    = tbl_count[idx];
    end else begin
      t.status = ST_RANGE;
    end
    t.used = USED_W'(n_used);
    return t;
  endfunction

  function automatic void flag(string what, logic [63:0] want, logic [63:0] got);
    miss_count++;
    if (miss_count <= 10) $display("mismatch on %s: expected %0h, got %0h", what, want, got);
  endfunction

  always @(posedge clk) begin : watch
    tally_t t;
    if (rst) begin
      tally_q.delete();
      n_used   = 0;
      cur_word = '0;
      cur_len  = 0;
      cur_over = 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        case (kind)
          KIND_TEXT: begin
            if (is_letter(text_byte)) begin
              if (cur_len < MAX_WORD_CHARS) begin
                cur_word[cur_len*8 +: 8] = text_byte;
                cur_len++;
              end else begin
                cur_over = 1'b1;
              end
            end else if (cur_len != 0) begin
              tally_q.push_back(close_word());
            end
          end
          KIND_FLUSH: begin
            if (cur_len != 0) tally_q.push_back(close_word());
          end
          KIND_READ: begin
            tally_q.push_back(read_entry(entry_index));
          end
          default: begin
          end
        endcase
      end
      if (result_valid && result_ready) begin
        if (tally_q.size() == 0) begin
          miss_count++;
          if (miss_count <= 10) $display("unexpected result transaction, status %0d", status);
        end else begin
          t = tally_q.pop_front();
          if (status !== t.status) flag("status", 64'(t.status), 64'(status));
          if (entry_position !== t.pos) flag("entry_position", 64'(t.pos), 64'(entry_position));
          if (word_low !== t.lo) flag("word_low", t.lo, word_low);
          if (word_high !== t.hi) flag("word_high", t.hi, word_high);
          if (word_length !== t.len) flag("word_length", 64'(t.len), 64'(word_length));
          if (occurrences !== t.occ) flag("occurrences", 64'(t.occ), 64'(occurrences));
          if (entries_used !== t.used) flag("entries_used", 64'(t.used), 64'(entries_used));
          if (truncated !== t.trunc) flag("truncated", 64'(t.trunc), 64'(truncated));
        end
      end
    end
    owed_n = tally_q.size();
  end

endmodule

FILE: sim/tb_top.sv
// testbench top: drives text, flush and read transactions into the counter and gives the verdict
module tb_top;
  import wfc_pkg::*;

  localparam int         TEXT_ITEMS  = 580;
  localparam int         VOCAB       = 16;
  localparam int         VOCAB_MAX   = 20;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic                  clk;
  logic                  rst;
  logic                  item_valid;
  logic                  item_ready;
  logic [1:0]            kind;
  logic [7:0]            text_byte;
  logic [IDX_W-1:0]      entry_index;
  logic                  result_valid;
  logic                  result_ready;
  logic [2:0]            status;
  logic [IDX_W-1:0]      entry_position;
  logic [63:0]           word_low;
  logic [63:0]           word_high;
  logic [LEN_W-1:0]      word_length;
  logic [COUNT_BITS-1:0] occurrences;
  logic [USED_W-1:0]     entries_used;
  logic                  truncated;

  int   mismatches;
  int   results_owed;
  int   words_stored;
  int   sent;
  bit   quiet;
  logic [7:0] vocab [VOCAB][VOCAB_MAX];
  int   vocab_len [VOCAB];

  word_frequency_counter dut (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .kind          (kind),
    .text_byte     (text_byte),
    .entry_index   (entry_index),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .status        (status),
    .entry_position(entry_position),
    .word_low      (word_low),
    .word_high     (word_high),
    .word_length   (word_length),
    .occurrences   (occurrences),
    .entries_used  (entries_used),
    .truncated     (truncated)
  );

  wfc_checker chk (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .kind          (kind),
    .text_byte     (text_byte),
    .entry_index   (entry_index),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .status        (status),
    .entry_position(entry_position),
    .word_low      (word_low),
    .word_high     (word_high),
    .word_length   (word_length),
    .occurrences   (occurrences),
    .entries_used  (entries_used),
    .truncated     (truncated),
    .mismatches    (mismatches),
    .results_owed  (results_owed),
    .words_stored  (words_stored)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial begin
    #20000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] any_letter();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(65, 90));
    return 8'($urandom_range(97, 122));
  endfunction

  function automatic logic [7:0] any_separator();
    case ($urandom_range(0, 2))
      0: return 8'($urandom_range(0, 64));
      1: return 8'($urandom_range(91, 96));
      default: return 8'($urandom_range(123, 255));
    endcase
  endfunction

  task automatic send(input logic [1:0] k, input logic [7:0] b, input logic [IDX_W-1:0] idx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid  <= 1'b1;
    kind        <= k;
    text_byte   <= b;
    entry_index <= idx;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    if (k != KIND_UNUSED) sent++;
  endtask

  task automatic send_letter(input logic [7:0] b);
    send(KIND_TEXT, b, IDX_W'($urandom));
  endtask

  task automatic send_read();
    logic [IDX_W-1:0] idx;
    if (words_stored > 0 && $urandom_range(0, 3) != 0) begin
      idx = IDX_W'($urandom_range(0, words_stored - 1));
    end else begin
      idx = IDX_W'($urandom_range(0, TABLE_ENTRIES - 1));
    end
    send(KIND_READ, 8'($urandom), idx);
  endtask

  task automatic end_word();
    if ($urandom_range(0, 3) == 0) send(KIND_FLUSH, 8'($urandom), IDX_W'($urandom));
    else send_letter(any_separator());
  endtask

  task automatic fresh_word(input int n);
    for (int i = 0; i < n; i++) send_letter(any_letter());
    end_word();
  endtask

  initial begin : ready_side
    int stall;
    result_ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  initial begin : stimulus
    int r;
    int v;
    rst         <= 1'b1;
    item_valid  <= 1'b0;
    kind        <= KIND_TEXT;
    text_byte   <= 8'h00;
    entry_index <= '0;
    quiet = 1'b0;
    sent  = 0;

    for (int w = 0; w < VOCAB; w++) begin
      if (w == 0) vocab_len[w] = VOCAB_MAX;
      else if (w == 1) vocab_len[w] = MAX_WORD_CHARS;
      else if (w == 2) vocab_len[w] = MAX_WORD_CHARS + 1;
      else if ($urandom_range(0, 4) == 0) vocab_len[w] = $urandom_range(9, VOCAB_MAX);
      else vocab_len[w] = $urandom_range(1, 8);
      for (int i = 0; i < VOCAB_MAX; i++) begin
        vocab[w][i] = (w == 1) ? vocab[0][i] : any_letter();
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, idle separators, letter boundaries, read with word pending
    send(KIND_READ, 8'hFF, '0);
    send(KIND_FLUSH, 8'h00, '1);
    send(KIND_TEXT, 8'hFF, '0);
    send(KIND_UNUSED, 8'h41, '1);
    send_letter(8'h41);
    send_letter(8'h40);
    send_letter(8'h5A);
    send_letter(8'h61);
    send_letter(8'h7A);
    send_letter(8'h5B);
    send_letter(8'h41);
    send_letter(8'h60);
    send_letter(8'h61);
    send(KIND_READ, 8'h00, IDX_W'(1));
    send_letter(8'h7B);
    send_letter(8'h7A);
    send(KIND_FLUSH, 8'hFF, '0);
    send(KIND_READ, 8'h00, '0);
    send(KIND_READ, 8'hFF, '1);
    send(KIND_TEXT, 8'h00, '1);

    // random text over a small vocabulary so words repeat
    while (sent < TEXT_ITEMS) begin
      if ($urandom_range(0, 29) == 0) quiet = ($urandom_range(0, 2) == 0);
      r = $urandom_range(0, 99);
      if (r < 65) begin
        v = $urandom_range(0, VOCAB - 1);
        for (int i = 0; i < vocab_len[v]; i++) begin
          send_letter(vocab[v][i]);
          if ($urandom_range(0, 39) == 0) send_read();
        end
        end_word();
      end else if (r < 75) begin
        fresh_word($urandom_range(0, 4) == 0 ? $urandom_range(9, 20) : $urandom_range(1, 6));
      end else if (r < 87) begin
        send_read();
      end else if (r < 96) begin
        send(KIND_TEXT, 8'($urandom), IDX_W'($urandom));
      end else if (r < 98) begin
        send(KIND_FLUSH, 8'($urandom), IDX_W'($urandom));
      end else begin
        send(KIND_UNUSED, 8'($urandom), IDX_W'($urandom));
      end
    end

    // long words and reads at the end of the text
    quiet = 1'b0;
    fresh_word(18);
    for (int i = 0; i < vocab_len[0]; i++) send_letter(vocab[0][i]);
    end_word();
    send(KIND_READ, 8'($urandom), '1);
    send(KIND_READ, 8'($urandom), '0);
    send(KIND_READ, 8'($urandom), IDX_W'(TABLE_ENTRIES / 2));
    send_read();

    item_valid <= 1'b0;
    while (results_owed != 0) @(posedge clk);
    repeat (TABLE_ENTRIES + 64) @(posedge clk);
    if (mismatches == 0 && results_owed == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
